// ===== src/cvn_pkg.sv =====
// Package for the complex vector normaliser: widths, buffer depth and controller state codes.
// Depends on nothing; every other file refers to it by scoped names.
package cvn_pkg;
	localparam int MaxLen    = 64;
	localparam int AddrW     = 6;
	localparam int CountW    = 7;
	localparam int DataW     = 16;
	localparam int EnergyW   = 38;
	localparam int RadW      = 54;
	localparam int NormW     = 27;
	localparam int QuotW     = 16;

	localparam logic [2:0] StLoad  = 3'd0;
	localparam logic [2:0] StRoot  = 3'd1;
	localparam logic [2:0] StRead  = 3'd2;
	localparam logic [2:0] StWait  = 3'd3;
	localparam logic [2:0] StDiv   = 3'd4;
	localparam logic [2:0] StEmit  = 3'd5;
endpackage

// ===== src/complex_vector_normalize.sv =====
// Top level of the complex vector normaliser: buffer, energy accumulator and sequencer.
// Depends on cvn_pkg, cvn_sqrt and cvn_div.
//
// Elements are taken one per cycle while busy is low.
// When an element marked last (or the 64th) is taken, busy rises: the bit-serial square
// root forms the norm, then each element is read from the buffer, given a wait state for
// the data to land, divided by the norm in two passes of the radix-2 divider, real part
// then imaginary part, and emitted; a zero norm skips the divider passes. Each result
// appears for one cycle on the strobe valid; the receiver cannot stall it. busy falls in the
// cycle that carries the last result.
module complex_vector_normalize (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic signed [15:0] in_real,
	input  logic signed [15:0] in_imag,
	input  logic               last_in,
	output logic               valid,
	output logic signed [15:0] out_real,
	output logic signed [15:0] out_imag,
	output logic [26:0]        vector_norm_value,
	output logic               zero_norm,
	output logic               last_out
);
	logic [cvn_pkg::DataW-1:0]   real_mem [cvn_pkg::MaxLen];
	logic [cvn_pkg::DataW-1:0]   imag_mem [cvn_pkg::MaxLen];
	logic [cvn_pkg::EnergyW-1:0] energy_q;
	logic [cvn_pkg::CountW-1:0]  count_q;
	logic [cvn_pkg::CountW-1:0]  idx_q;
	logic [2:0]                  state_q;
	logic                        part_q;
	logic [cvn_pkg::DataW-1:0]   rd_real_q;
	logic [cvn_pkg::DataW-1:0]   rd_imag_q;
	logic [cvn_pkg::QuotW-1:0]   qr_q;
	logic [cvn_pkg::NormW-1:0]   norm_q;
	logic                        take;
	logic                        ends;
	logic [31:0]                 sq_sum;
	logic                        sq_start;
	logic                        sq_done;
	logic [cvn_pkg::NormW-1:0]   sq_root;
	logic                        dv_start;
	logic                        dv_done;
	logic [cvn_pkg::QuotW-1:0]   dv_q;

	assign take   = start && !busy;
	assign ends   = last_in || (count_q == 7'(cvn_pkg::MaxLen - 1));
	assign busy   = (state_q != cvn_pkg::StLoad);
	assign sq_sum = 32'(in_real * in_real) + 32'(in_imag * in_imag);
	assign sq_start = take && ends;

	cvn_sqrt u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (sq_start),
		.radicand ({energy_q + cvn_pkg::EnergyW'(sq_sum), 16'd0}),
		.done     (sq_done),
		.root     (sq_root)
	);

	cvn_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (dv_start),
		.x      (part_q ? rd_imag_q : rd_real_q),
		.norm   (norm_q),
		.done   (dv_done),
		.q      (dv_q)
	);

	always_ff @(posedge clk) begin
		if (take) begin
			real_mem[count_q[cvn_pkg::AddrW-1:0]] <= in_real;
			imag_mem[count_q[cvn_pkg::AddrW-1:0]] <= in_imag;
		end
		rd_real_q <= real_mem[idx_q[cvn_pkg::AddrW-1:0]];
		rd_imag_q <= imag_mem[idx_q[cvn_pkg::AddrW-1:0]];
		if (sq_done) norm_q <= sq_root;
		if (dv_done && !part_q) qr_q <= dv_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= cvn_pkg::StLoad;
			energy_q <= '0;
			count_q  <= '0;
			idx_q    <= '0;
			part_q   <= 1'b0;
			dv_start <= 1'b0;
			valid    <= 1'b0;
		end else begin
			dv_start <= 1'b0;
			valid    <= 1'b0;
			case (state_q)
				cvn_pkg::StLoad: begin
					if (take) begin
						count_q  <= count_q + 7'd1;
						energy_q <= energy_q + cvn_pkg::EnergyW'(sq_sum);
						if (ends) state_q <= cvn_pkg::StRoot;
					end
				end
				cvn_pkg::StRoot: begin
					idx_q <= '0;
					if (sq_done) state_q <= cvn_pkg::StRead;
				end
				cvn_pkg::StRead: begin
					// Memory read is registered; StWait lets the data land in rd_real_q and rd_imag_q.
					part_q  <= 1'b0;
					state_q <= cvn_pkg::StWait;
				end
				cvn_pkg::StWait: begin
					if (norm_q == '0) begin
						state_q <= cvn_pkg::StEmit;
					end else begin
						dv_start <= 1'b1;
						state_q  <= cvn_pkg::StDiv;
					end
				end
				cvn_pkg::StDiv: begin
					if (dv_done) begin
						if (!part_q) begin
							part_q   <= 1'b1;
							dv_start <= 1'b1;
						end else begin
							state_q <= cvn_pkg::StEmit;
						end
					end
				end
				cvn_pkg::StEmit: begin
					valid <= 1'b1;
					idx_q <= idx_q + 7'd1;
					if (idx_q + 7'd1 == count_q) begin
						state_q  <= cvn_pkg::StLoad;
						count_q  <= '0;
						energy_q <= '0;
					end else begin
						state_q <= cvn_pkg::StRead;
					end
				end
				default: state_q <= cvn_pkg::StLoad;
			endcase
		end
	end

	logic [cvn_pkg::QuotW-1:0] qi_q;
	logic                      lst_q;
	always_ff @(posedge clk) begin
		if (state_q == cvn_pkg::StEmit) begin
			qi_q  <= (norm_q == '0) ? '0 : dv_q;
			lst_q <= (idx_q + 7'd1 == count_q);
		end
	end

	assign out_real          = (norm_q == '0) ? 16'sd0 : qr_q;
	assign out_imag          = qi_q;
	assign vector_norm_value = norm_q;
	assign zero_norm         = (norm_q == '0);
	assign last_out          = lst_q;
endmodule

// ===== src/cvn_sqrt.sv =====
// Bit-serial floor square root: one result bit per cycle, 27-bit root.
// Depends on cvn_pkg.
module cvn_sqrt (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [cvn_pkg::RadW-1:0]    radicand,
	output logic                        done,
	output logic [cvn_pkg::NormW-1:0]   root
);
	logic [cvn_pkg::RadW-1:0]  rad_q;
	logic [cvn_pkg::NormW+1:0] rem_q;
	logic [cvn_pkg::NormW-1:0] root_q;
	logic [4:0]                cnt_q;
	logic                      run_q;
	logic [cvn_pkg::NormW+1:0] trial;
	logic [cvn_pkg::NormW+1:0] trial_sub;

	// Bring down two radicand bits, then try subtracting 4*root + 1.
	assign trial     = {rem_q[cvn_pkg::NormW-1:0], rad_q[cvn_pkg::RadW-1 -: 2]};
	assign trial_sub = {root_q, 2'b01};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			done  <= 1'b0;
			cnt_q <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= 5'(cvn_pkg::NormW - 1);
			end else if (run_q) begin
				if (cnt_q == '0) begin
					run_q <= 1'b0;
					done  <= 1'b1;
				end
				cnt_q <= cnt_q - 5'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rad_q  <= radicand;
			rem_q  <= '0;
			root_q <= '0;
		end else if (run_q) begin
			rad_q <= {rad_q[cvn_pkg::RadW-3:0], 2'b00};
			if (trial >= trial_sub) begin
				rem_q  <= trial - trial_sub;
				root_q <= {root_q[cvn_pkg::NormW-2:0], 1'b1};
			end else begin
				rem_q  <= trial;
				root_q <= {root_q[cvn_pkg::NormW-2:0], 1'b0};
			end
		end
	end

	assign root = root_q;
endmodule

// ===== src/cvn_div.sv =====
// Radix-2 restoring divider of |x| * 2^23 by the norm, saturated to Q1.15, 17 steps.
// Depends on cvn_pkg.
module cvn_div (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [cvn_pkg::DataW-1:0]   x,
	input  logic [cvn_pkg::NormW-1:0]   norm,
	output logic                        done,
	output logic [cvn_pkg::QuotW-1:0]   q
);
	// Quotients of interest fit 17 bits once the saturation case is caught,
	// so the dividend needs only 17 steps after a pre-check: mag*2^23 >= norm*2^17.
	logic [cvn_pkg::NormW:0]   rem_q;
	logic [16:0]               num_q;
	logic [16:0]               quo_q;
	logic [cvn_pkg::NormW-1:0] den_q;
	logic                      neg_q;
	logic                      ovf_q;
	logic [4:0]                cnt_q;
	logic                      run_q;
	logic [cvn_pkg::NormW:0]   trial;
	logic [15:0]               mag;
	logic [16:0]               qsat;

	assign mag     = x[15] ? 16'(-x) : x;
	assign trial   = {rem_q[cvn_pkg::NormW-1:0], num_q[16]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			done  <= 1'b0;
			cnt_q <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= 5'd16;
			end else if (run_q) begin
				if (cnt_q == '0) begin
					run_q <= 1'b0;
					done  <= 1'b1;
				end
				cnt_q <= cnt_q - 5'd1;
			end
		end
	end

	// The dividend's upper part, mag * 2^6, is loaded as the starting remainder;
	// the 17 low bits (all zero) are shifted in as quotient bits are formed.
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= (cvn_pkg::NormW+1)'({mag, 6'd0});
			num_q <= '0;
			quo_q <= '0;
			den_q <= norm;
			neg_q <= x[15];
			ovf_q <= cvn_pkg::NormW'({mag, 6'd0}) >= norm;
		end else if (run_q) begin
			num_q <= {num_q[15:0], 1'b0};
			if (trial >= {1'b0, den_q}) begin
				rem_q <= trial - {1'b0, den_q};
				quo_q <= {quo_q[15:0], 1'b1};
			end else begin
				rem_q <= trial;
				quo_q <= {quo_q[15:0], 1'b0};
			end
		end
	end

	always_comb begin
		if (ovf_q) qsat = 17'h1FFFF;
		else       qsat = quo_q;
		if (neg_q) begin
			if (qsat > 17'd32768) q = 16'h8000;
			else                  q = 16'(17'h10000 - qsat);
		end else begin
			if (qsat > 17'd32767) q = 16'h7FFF;
			else                  q = qsat[15:0];
		end
	end
endmodule

// ===== tb/complex_vector_normalize_test.sv =====
// Testbench for complex_vector_normalize: directed table of elements, a full 64-element vector, then random vectors.
// Depends on cvn_pkg and the complex_vector_normalize RTL; every result is checked in order.
`timescale 1ns / 100ps

module complex_vector_normalize_test;

	typedef struct packed {
		logic signed [15:0] re;
		logic signed [15:0] im;
		logic [26:0]        norm;
		logic               zero;
		logic               last;
	} norm_result_t;

	typedef struct {
		logic signed [15:0] re;
		logic signed [15:0] im;
		logic               last;
		logic               known;
		norm_result_t       want;
	} table_row_t;

	logic               clk;
	logic               arst_n;
	logic               start;
	logic               busy;
	logic signed [15:0] in_real;
	logic signed [15:0] in_imag;
	logic               last_in;
	logic               valid;
	logic signed [15:0] out_real;
	logic signed [15:0] out_imag;
	logic [26:0]        vector_norm_value;
	logic               zero_norm;
	logic               last_out;

	logic [15:0]  vec_real [cvn_pkg::MaxLen];
	logic [15:0]  vec_imag [cvn_pkg::MaxLen];
	logic [37:0]  energy;
	int           elem_count;
	norm_result_t pending_results[$];
	norm_result_t pinned_results[$];
	logic         pinned_flag[$];
	int           mismatches;
	int           timed_out;
	table_row_t   rows[$];

	complex_vector_normalize u_top (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.in_real(in_real), .in_imag(in_imag), .last_in(last_in),
		.valid(valid), .out_real(out_real), .out_imag(out_imag),
		.vector_norm_value(vector_norm_value), .zero_norm(zero_norm), .last_out(last_out)
	);

	initial clk = 1'b0;
	always #4 clk = ~clk;

	function automatic logic [63:0] isqrt(logic [63:0] v);
		logic [63:0] rem;
		logic [63:0] root;
		logic [63:0] b;
		rem = v;
		root = 0;
		b = 64'd1 << 62;
		while (b > rem) b = b >> 2;
		while (b != 0) begin
			if (rem >= root + b) begin
				rem = rem - (root + b);
				root = (root >> 1) + b;
			end else begin
				root = root >> 1;
			end
			b = b >> 2;
		end
		return root;
	endfunction

	function automatic logic [15:0] scaled_part(logic [15:0] raw, logic [26:0] norm);
		logic [63:0] mag;
		logic [63:0] q;
		mag = raw[15] ? 64'(-$signed(raw)) & 64'hFFFF : 64'(raw);
		q = (mag << 23) / norm;
		if (raw[15]) begin
			if (q > 32768) q = 32768;
			return 16'(17'h10000 - q);
		end
		if (q > 32767) q = 32767;
		return 16'(q);
	endfunction

	// Stores one element and, when the vector ends, queues its normalised results.
	task automatic absorb_element(logic [15:0] re, logic [15:0] im, logic last);
		logic [26:0]  norm;
		norm_result_t r;
		vec_real[elem_count] = re;
		vec_imag[elem_count] = im;
		energy = energy + 38'($signed(re) * $signed(re)) + 38'($signed(im) * $signed(im));
		elem_count++;
		if (!last && elem_count < cvn_pkg::MaxLen) return;
		norm = 27'(isqrt(64'(energy) << 16));
		for (int k = 0; k < elem_count; k++) begin
			r.norm = norm;
			r.zero = (norm == 0);
			r.re = r.zero ? 16'sd0 : scaled_part(vec_real[k], norm);
			r.im = r.zero ? 16'sd0 : scaled_part(vec_imag[k], norm);
			r.last = (k + 1 == elem_count);
			pending_results.push_back(r);
		end
		energy = 0;
		elem_count = 0;
	endtask

	// busy only changes at a rising edge, so it is sampled at the falling edge before.
	task automatic send_element(logic [15:0] re, logic [15:0] im, logic last);
		logic free;
		start <= 1'b1;
		in_real <= re;
		in_imag <= im;
		last_in <= last;
		forever begin
			@(negedge clk);
			free = !busy;
			@(posedge clk);
			if (free) break;
		end
		absorb_element(re, im, last);
	endtask

	task automatic idle_cycles(int n);
		start <= 1'b0;
		repeat (n) @(posedge clk);
	endtask

	task automatic add_row(int re, int im, logic last, logic known, norm_result_t want);
		table_row_t t;
		t.re = 16'(re);
		t.im = 16'(im);
		t.last = last;
		t.known = known;
		t.want = want;
		rows.push_back(t);
	endtask

	always @(posedge clk) begin
		norm_result_t got;
		norm_result_t want;
		norm_result_t pin;
		logic         has_pin;
		if (arst_n && valid) begin
			got = '{out_real, out_imag, vector_norm_value, zero_norm, last_out};
			if (pending_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result %p", got);
			end else begin
				want = pending_results.pop_front();
				has_pin = pinned_flag.size() > 0 ? pinned_flag.pop_front() : 1'b0;
				pin = pinned_results.size() > 0 ? pinned_results.pop_front() : want;
				if (has_pin && pin != want) begin
					mismatches++;
					if (mismatches <= 10) $display("table row %p disagrees with %p", pin, want);
				end
				if (got != want) begin
					mismatches++;
					if (mismatches <= 10) $display("expected %p, got %p", want, got);
				end
			end
		end
	end

	initial begin
		timed_out = 0;
		#30ms;
		timed_out = 1;
		$display("== FAIL ==");
		$finish;
	end

	initial begin
		norm_result_t none;
		int n;
		int burst;
		int sent;
		int len;
		logic [15:0] re;
		logic [15:0] im;
		none = '0;
		mismatches = 0;
		energy = 0;
		elem_count = 0;
		start = 1'b0;
		in_real = '0;
		in_imag = '0;
		last_in = 1'b0;
		arst_n = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Zero vector right after reset, single-element extremes with obvious results, then two multi-element vectors.
		add_row(0, 0, 1'b0, 1'b0, none);
		add_row(0, 0, 1'b1, 1'b0, none);
		add_row(32767, 0, 1'b1, 1'b1, '{16'sd32767, 16'sd0, 27'd8388352, 1'b0, 1'b1});
		add_row(-32768, 0, 1'b1, 1'b1, '{-16'sd32768, 16'sd0, 27'd8388608, 1'b0, 1'b1});
		add_row(0, -32768, 1'b1, 1'b1, '{16'sd0, -16'sd32768, 27'd8388608, 1'b0, 1'b1});
		add_row(1, 0, 1'b1, 1'b1, '{16'sd32767, 16'sd0, 27'd256, 1'b0, 1'b1});
		add_row(-32768, -32768, 1'b0, 1'b0, none);
		add_row(32767, 32767, 1'b0, 1'b0, none);
		add_row(-1, 1, 1'b1, 1'b0, none);
		add_row(12345, -23456, 1'b0, 1'b0, none);
		add_row(0, 0, 1'b1, 1'b0, none);
		for (int i = 0; i < rows.size(); i++) begin
			// Rows marked known are cross-checked against the predictor; the others, zero vectors included, rely on it alone.
			if (rows[i].known) begin
				pinned_flag.push_back(1'b1);
				pinned_results.push_back(rows[i].want);
			end else begin
				pinned_flag.push_back(1'b0);
				pinned_results.push_back(none);
			end
			send_element(rows[i].re, rows[i].im, rows[i].last);
		end
		idle_cycles(1);
		while (pending_results.size() != 0) @(posedge clk);
		pinned_flag.delete();
		pinned_results.delete();

		// A full 64-element buffer ends the vector without last_in.
		for (int i = 0; i < cvn_pkg::MaxLen; i++) send_element(16'($urandom), 16'($urandom), 1'b0);
		idle_cycles(1);

		sent = 0;
		while (sent < 200) begin
			len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 64) : $urandom_range(1, 6);
			burst = $urandom_range(1, 8);
			for (int i = 0; i < len; i++) begin
				case ($urandom_range(0, 5))
					0: begin re = 0; im = 0; end
					1: begin
						re = 16'($urandom_range(0, 7) - 4);
						im = 16'($urandom_range(0, 7) - 4);
					end
					2: begin
						re = $urandom_range(0, 1) ? 16'h8000 : 16'h7FFF;
						im = 16'($urandom);
					end
					default: begin re = 16'($urandom); im = 16'($urandom); end
				endcase
				send_element(re, im, i == len - 1);
				sent++;
				burst--;
				if (burst == 0) begin
					burst = $urandom_range(1, 8);
					if ($urandom_range(0, 2) == 0) idle_cycles($urandom_range(1, 5));
				end
			end
			if (sent > 140 && sent < 150) begin
				idle_cycles(1);
				while (pending_results.size() != 0) @(posedge clk);
			end
		end
		idle_cycles(1);
		n = 0;
		while (pending_results.size() != 0 && n < 100000) begin
			@(posedge clk);
			n++;
		end
		repeat (50) @(posedge clk);
		if (mismatches == 0 && pending_results.size() == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule
